[hw/rtl/hcbp_pkg.sv]
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types and constants shared by the huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	localparam int unsigned CODE_W  = 32;
	localparam int unsigned LEN_W   = 6;
	localparam int unsigned ENTRY_W = CODE_W + LEN_W;
	localparam int unsigned MAX_OUT = 4;

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_ENCODE = 2'd1;
	localparam logic [1:0] FUNC_FLUSH  = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic [7:0]        symbol;
		logic [CODE_W-1:0] code_word;
		logic [LEN_W-1:0]  code_length;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] word;
	} entry_t;

	// bytes produced by one request plus the leftover bit state
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;
		logic [2:0]              count;
		logic [6:0]              next_bits;
		logic [2:0]              next_count;
	} pack_res_t;

endpackage

[hw/rtl/hcbp_ram.sv]
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hcbp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/hcbp_pack.sv]
// ----------------------------------------------------------------------------
// hcbp_pack
// Appends a code word to the leftover bits and splits the result into
// output bytes, or pads the leftover bits for a flush.
// ----------------------------------------------------------------------------
module hcbp_pack (
	input  logic [1:0]         func,
	input  logic               sym_ok,
	input  hcbp_pkg::entry_t   entry,
	input  logic [6:0]         pend_bits,
	input  logic [2:0]         pend_count,
	output hcbp_pkg::pack_res_t res
);
	import hcbp_pkg::*;

	localparam int unsigned ACC_W = CODE_W + 7;
	localparam int unsigned ALN_W = 40;

	logic [ACC_W-1:0] acc;
	logic [5:0]       total;
	logic [ALN_W-1:0] aligned;

	always_comb begin
		acc     = (ACC_W'(pend_bits) << entry.len) | ACC_W'(entry.word);
		total   = 6'(pend_count) + entry.len;
		// first code bit moves to bit 39
		aligned = ALN_W'(acc) << (6'd40 - total);

		res.bytes      = '0;
		res.count      = 3'd0;
		res.next_bits  = pend_bits;
		res.next_count = pend_count;

		unique case (func)
			FUNC_ENCODE: begin
				if (sym_ok) begin
					for (int k = 0; k < MAX_OUT; k++) begin
						res.bytes[k] = aligned[ALN_W-1-8*k -: 8];
					end
					res.count      = total[5:3];
					res.next_count = total[2:0];
					res.next_bits  = acc[6:0] & ~(7'h7F << total[2:0]);
				end
			end
			FUNC_FLUSH: begin
				res.bytes[0]   = 8'({1'b0, pend_bits} << (4'd8 - {1'b0, pend_count}));
				res.count      = (pend_count != 3'd0) ? 3'd1 : 3'd0;
				res.next_bits  = 7'd0;
				res.next_count = 3'd0;
			end
			default: begin
				res.count = 3'd0;
			end
		endcase
	end

endmodule

[hw/rtl/hcbp_obuf.sv]
// ----------------------------------------------------------------------------
// hcbp_obuf
// Holds the bytes of one request and hands them out one per accepted beat.
// ----------------------------------------------------------------------------
module hcbp_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  hcbp_pkg::pack_res_t res,
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_ready,
	output hcbp_pkg::out_item_t out_data
);
	import hcbp_pkg::*;

	logic [MAX_OUT-1:0][7:0] bytes_q;
	logic [2:0]              rem_q;
	logic                    pop;

	assign out_valid = (rem_q != 3'd0);
	assign pop       = out_valid && out_ready;
	assign can_load  = (rem_q == 3'd0) || ((rem_q == 3'd1) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (load) begin
			rem_q <= res.count;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
		end else if (pop) begin
			bytes_q <= {8'h00, bytes_q[MAX_OUT-1:1]};
		end
	end

	assign out_data.out_byte = bytes_q[0];
	assign out_data.last     = (rem_q == 3'd1);

endmodule

[hw/rtl/huffman_code_bit_packer_unit.sv]
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// Path: a request accepted at one edge passes the registered table read and
// the packing into the byte buffer, and waits there while the buffer is full.
// Throughput: one request per cycle while each yields at most one byte and
// out_ready is high; a request holds the output till its bytes (up to 4) leave.
// Reset clears the leftover bits and all valids; the code table is not reset.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_unit #(
	parameter int unsigned SYMBOLS      = 256,
	parameter int unsigned MAX_CODE_LEN = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hcbp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hcbp_pkg::out_item_t out_data
);
	import hcbp_pkg::*;

	localparam int unsigned AW        = $clog2(SYMBOLS);
	localparam int unsigned LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

	logic        in_acc;
	logic        sym_ok;
	logic        tbl_we;
	logic [LEN_W-1:0]  sat_len;
	logic [CODE_W:0]   word_mask;
	entry_t      wr_entry;
	entry_t      rd_entry;

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic        sym_ok_s1;
	logic [6:0]  pend_bits_q;
	logic [2:0]  pend_count_q;

	pack_res_t   res;
	logic        can_load;
	logic        adv_s1;
	logic        buf_load;

	assign in_acc = in_valid && in_ready;
	assign sym_ok = ({1'b0, in_data.symbol} < 9'(SYMBOLS));

	// saturate the length and drop code bits above it
	always_comb begin
		sat_len       = (in_data.code_length > LEN_W'(LEN_LIMIT)) ?
		                LEN_W'(LEN_LIMIT) : in_data.code_length;
		word_mask     = ((CODE_W+1)'(1) << sat_len) - (CODE_W+1)'(1);
		wr_entry.len  = sat_len;
		wr_entry.word = in_data.code_word & word_mask[CODE_W-1:0];
	end

	assign tbl_we = in_acc && (in_data.func == FUNC_LOAD) && sym_ok;

	hcbp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SYMBOLS)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (in_data.symbol[AW-1:0]),
		.wdata (wr_entry),
		.re    (in_acc),
		.raddr (in_data.symbol[AW-1:0]),
		.rdata (rd_entry)
	);

	hcbp_pack u_pack (
		.func       (func_s1),
		.sym_ok     (sym_ok_s1),
		.entry      (rd_entry),
		.pend_bits  (pend_bits_q),
		.pend_count (pend_count_q),
		.res        (res)
	);

	// a request with no bytes never waits for the buffer
	assign adv_s1   = valid_s1 && ((res.count == 3'd0) || can_load);
	assign buf_load = adv_s1 && (res.count != 3'd0);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			pend_bits_q  <= 7'd0;
			pend_count_q <= 3'd0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				pend_bits_q  <= res.next_bits;
				pend_count_q <= res.next_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1   <= in_data.func;
			sym_ok_s1 <= sym_ok;
		end
	end

	hcbp_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (buf_load),
		.res       (res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives load, encode, flush and unused requests into the huffman code bit
// packer. A short table of hand-picked requests comes first, then a long
// random run. Each output byte is checked against the bytes a typed row lists
// or a local bit-packing predictor. Both block sides idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import hcbp_pkg::*;

	localparam int unsigned SYM_COUNT   = 256;
	localparam int unsigned MAX_LEN     = 32;
	localparam int unsigned LEN_CAP     = (MAX_LEN < CODE_W) ? MAX_LEN : CODE_W;
	localparam logic [1:0]  FUNC_UNUSED = 2'd3;
	localparam int          NUM_ROWS    = 25;
	localparam int          NUM_RANDOM  = 445;
	localparam int          CALM_TAIL   = 60;
	localparam int          STALL_LIMIT = 1000;
	localparam int          DRAIN_WAIT  = 8;

	typedef struct {
		in_item_t    req;
		bit          typed;
		int          nbytes;
		logic [31:0] bytes;
	} row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b1;
	out_item_t out_data;

	huffman_code_bit_packer_unit #(
		.SYMBOLS     (SYM_COUNT),
		.MAX_CODE_LEN(MAX_LEN)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [CODE_W-1:0] code_words [SYM_COUNT];
	logic [LEN_W-1:0]  code_lens [SYM_COUNT];
	bit                known [SYM_COUNT];
	logic [7:0]        known_syms [$];
	logic [6:0]        held_bits = '0;
	logic [2:0]        held_count = '0;
	out_item_t         burst_bytes [MAX_OUT];
	int                burst_n;

	out_item_t bytes_due [$];
	row_t      rows [NUM_ROWS];

	bit in_taken = 1'b0;
	bit calm = 1'b0;
	bit gappy = 1'b1;
	int errors = 0;
	int idle_cycles = 0;
	int n_load = 0, n_encode = 0, n_flush = 0, n_other = 0, n_bytes = 0;

	// bytes one request produces, and the leftover bit state after it
	task automatic pack_request(input in_item_t r);
		logic [38:0]       acc;
		logic [32:0]       mask;
		int unsigned       clen;
		int unsigned       total;
		burst_n = 0;
		case (r.func)
			FUNC_LOAD: begin
				clen = (r.code_length > LEN_CAP) ? LEN_CAP : r.code_length;
				mask = (33'd1 << clen) - 33'd1;
				code_words[r.symbol] = r.code_word & mask[31:0];
				code_lens[r.symbol] = LEN_W'(clen);
				if (!known[r.symbol]) begin
					known[r.symbol] = 1'b1;
					known_syms.push_back(r.symbol);
				end
			end
			FUNC_ENCODE: begin
				clen = code_lens[r.symbol];
				acc = ({32'd0, held_bits} << clen) | {7'd0, code_words[r.symbol]};
				total = held_count + clen;
				while (total >= 8) begin
					total -= 8;
					burst_bytes[burst_n].out_byte = 8'(acc >> total);
					burst_bytes[burst_n].last = (total < 8);
					burst_n++;
				end
				held_bits = 7'(acc & ((39'd1 << total) - 39'd1));
				held_count = 3'(total);
			end
			FUNC_FLUSH: begin
				if (held_count != 0) begin
					// pad with zeros on the low side
					burst_bytes[0].out_byte = 8'({1'b0, held_bits} << (8 - held_count));
					burst_bytes[0].last = 1'b1;
					burst_n = 1;
				end
				held_bits = '0;
				held_count = '0;
			end
			default: ;
		endcase
	endtask

	function automatic in_item_t mk_req(logic [1:0] f, logic [7:0] s, logic [31:0] w,
			logic [5:0] l);
		in_item_t r;
		r.func = f;
		r.symbol = s;
		r.code_word = w;
		r.code_length = l;
		return r;
	endfunction

	task automatic issue(input in_item_t r, input bit typed, input int n,
			input logic [31:0] b);
		out_item_t o;
		pack_request(r);
		if (typed) begin
			for (int k = 0; k < n; k++) begin
				o.out_byte = b[8*(3-k) +: 8];
				o.last = (k == n - 1);
				bytes_due.push_back(o);
			end
		end else begin
			for (int k = 0; k < burst_n; k++)
				bytes_due.push_back(burst_bytes[k]);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (!in_taken)
			@(posedge clk);
		case (r.func)
			FUNC_LOAD:   n_load++;
			FUNC_ENCODE: n_encode++;
			FUNC_FLUSH:  n_flush++;
			default:     n_other++;
		endcase
	endtask

	task automatic maybe_pause();
		int n;
		if (!calm && gappy && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [5:0] pick_length();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 6'($urandom_range(1, 8));
			4, 5, 6:    return 6'($urandom_range(9, 20));
			7, 8:       return 6'($urandom_range(21, 32));
			default:    return $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
		endcase
	endfunction

	// handshakes are sampled mid-cycle, where every signal is settled
	always @(negedge clk) begin
		out_item_t e;
		in_taken = arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (bytes_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected byte %02h last %0b", out_data.out_byte,
						out_data.last);
			end else begin
				e = bytes_due.pop_front();
				n_bytes++;
				if (out_data.out_byte !== e.out_byte || out_data.last !== e.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
							e.out_byte, e.last, out_data.out_byte, out_data.last);
				end
			end
		end
		if (arst_n) begin
			if (in_taken || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("no progress for %0d cycles, %0d bytes still due", STALL_LIMIT,
					bytes_due.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	// receiver stalls in bursts, with stretches of none
	int  stall_left = 0;
	bit  rx_stalls = 1'b1;
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0)
			rx_stalls = !rx_stalls;
		if (calm) begin
			stall_left = 0;
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0)
				out_ready <= 1'b1;
		end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 18);
			out_ready <= 1'b0;
		end
	end

	initial begin
		in_item_t r;
		int       pick;
		rows[0]  = '{mk_req(FUNC_LOAD, 8'd0, 32'h0000_00A5, 6'd8), 1, 0, 32'h0};
		rows[1]  = '{mk_req(FUNC_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32), 1, 0, 32'h0};
		// overlong length saturates to the code width
		rows[2]  = '{mk_req(FUNC_LOAD, 8'd1, 32'h1234_5678, 6'd63), 1, 0, 32'h0};
		rows[3]  = '{mk_req(FUNC_LOAD, 8'd2, 32'hFFFF_FFFF, 6'd0), 1, 0, 32'h0};
		// bits above the length are dropped
		rows[4]  = '{mk_req(FUNC_LOAD, 8'd3, 32'hFFFF_FFFF, 6'd3), 1, 0, 32'h0};
		rows[5]  = '{mk_req(FUNC_LOAD, 8'd4, 32'h0000_0000, 6'd1), 1, 0, 32'h0};
		rows[6]  = '{mk_req(FUNC_UNUSED, 8'hAA, 32'h5555_5555, 6'd21), 1, 0, 32'h0};
		rows[7]  = '{mk_req(FUNC_FLUSH, 8'd0, 32'h0, 6'd0), 1, 0, 32'h0};
		rows[8]  = '{mk_req(FUNC_ENCODE, 8'd0, 32'h0, 6'd0), 1, 1, 32'hA500_0000};
		rows[9]  = '{mk_req(FUNC_ENCODE, 8'd255, 32'h0, 6'd0), 1, 4, 32'hFFFF_FFFF};
		rows[10] = '{mk_req(FUNC_ENCODE, 8'd2, 32'h0, 6'd0), 1, 0, 32'h0};
		rows[11] = '{mk_req(FUNC_ENCODE, 8'd3, 32'h0, 6'd0), 1, 0, 32'h0};
		rows[12] = '{mk_req(FUNC_FLUSH, 8'd0, 32'h0, 6'd0), 1, 1, 32'hE000_0000};
		rows[13] = '{mk_req(FUNC_ENCODE, 8'd1, 32'h0, 6'd0), 1, 4, 32'h1234_5678};
		rows[14] = '{mk_req(FUNC_ENCODE, 8'd3, 32'h0, 6'd0), 0, 0, 32'h0};
		rows[15] = '{mk_req(FUNC_ENCODE, 8'd1, 32'h0, 6'd0), 0, 0, 32'h0};
		rows[16] = '{mk_req(FUNC_ENCODE, 8'd4, 32'h0, 6'd0), 0, 0, 32'h0};
		rows[17] = '{mk_req(FUNC_FLUSH, 8'd0, 32'h0, 6'd0), 0, 0, 32'h0};
		rows[18] = '{mk_req(FUNC_LOAD, 8'd5, 32'h2AAA_AAAA, 6'd31), 0, 0, 32'h0};
		rows[19] = '{mk_req(FUNC_ENCODE, 8'd5, 32'h0, 6'd0), 0, 0, 32'h0};
		rows[20] = '{mk_req(FUNC_ENCODE, 8'd255, 32'h0, 6'd0), 0, 0, 32'h0};
		rows[21] = '{mk_req(FUNC_FLUSH, 8'd0, 32'h0, 6'd0), 0, 0, 32'h0};
		rows[22] = '{mk_req(FUNC_LOAD, 8'd0, 32'h0, 6'd7), 0, 0, 32'h0};
		rows[23] = '{mk_req(FUNC_ENCODE, 8'd0, 32'h0, 6'd0), 0, 0, 32'h0};
		rows[24] = '{mk_req(FUNC_FLUSH, 8'd0, 32'h0, 6'd0), 0, 0, 32'h0};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			issue(rows[i].req, rows[i].typed, rows[i].nbytes, rows[i].bytes);
			maybe_pause();
		end

		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i % 40 == 0)
				gappy = ($urandom_range(0, 3) != 0);
			if (i == NUM_RANDOM - CALM_TAIL)
				calm = 1'b1;
			r.symbol = 8'($urandom_range(0, 255));
			r.code_word = $urandom;
			r.code_length = pick_length();
			pick = $urandom_range(0, 99);
			if (pick < 22 || known_syms.size() == 0) begin
				r.func = FUNC_LOAD;
			end else if (pick < 85) begin
				// only symbols whose table entry has been written
				r.func = FUNC_ENCODE;
				r.symbol = known_syms[$urandom_range(0, known_syms.size() - 1)];
			end else if (pick < 96) begin
				r.func = FUNC_FLUSH;
			end else begin
				r.func = FUNC_UNUSED;
			end
			issue(r, 1'b0, 0, 32'h0);
			maybe_pause();
		end
		in_valid <= 1'b0;

		while (bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("requests: %0d loads, %0d encodes, %0d flushes, %0d unused",
			n_load, n_encode, n_flush, n_other);
		$display("bytes checked: %0d, table entries written: %0d, errors: %0d",
			n_bytes, known_syms.size(), errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
